// ----- rtl/rumble_request_scheduler_top_defines.svh -----
// Assertion macros for the rumble request scheduler.
// Used by rumble_request_scheduler_top; expects clk and arst_n in scope.
`ifndef RUMBLE_REQUEST_SCHEDULER_TOP_DEFINES_SVH
`define RUMBLE_REQUEST_SCHEDULER_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define RRS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define RRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rrs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the rumble request scheduler.
// No dependencies; used by every module of the block.
package rrs_pkg;

	localparam int DEF_REQUEST_SLOTS = 64;

	localparam int LEVEL_W   = 8;
	localparam int SLOT_W    = 6;
	localparam int FUNC_W    = 2;
	localparam int ON_W      = 16;
	localparam int OFF_W     = 3;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	// Input functions
	localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_SLOT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_OVR = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_RESTART  = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_EN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ON    = 1'd1;

	// Scheduler modes
	localparam logic [MODE_W-1:0] MODE_INITIAL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WIPE    = 2'd2;

	localparam logic [OFF_W-1:0] OFF_LIMIT    = 3'd5;
	localparam logic [ON_W-1:0]  ON_SAT       = 16'hFFFF;
	localparam logic [ON_W-1:0]  MAX_ON_RESET = 16'd7200;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [LEVEL_W-1:0] hold;
		logic [LEVEL_W-1:0] step;
		logic [LEVEL_W-1:0] accum;
	} slot_rec_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

// ----- rtl/rumble_request_scheduler_top.sv -----
// Rumble request scheduler: a ring of slot cells swept by one shared advance unit.
// Depends on rrs_pkg, rrs_cell, rrs_adv and rumble_request_scheduler_top_defines.svh.
// A running tick stays busy through the ring sweep, override and finish steps; its
// result is strobed in the next cycle. Other ticks and loads never go busy.
// The ring rotates one slot per cycle in the sweep; start is ignored while busy.
// Reset: asynchronous, clears every slot and counter, updates enabled, limit 7200.
`timescale 1ns / 1ps
`include "rumble_request_scheduler_top_defines.svh"
module rumble_request_scheduler_top #(
	parameter int REQUEST_SLOTS = rrs_pkg::DEF_REQUEST_SLOTS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command channel
	input  logic                            start,
	output logic                            busy,
	input  logic [rrs_pkg::FUNC_W-1:0]      func,
	input  logic [rrs_pkg::SLOT_W-1:0]      slot,
	input  logic [rrs_pkg::LEVEL_W-1:0]     intensity,
	input  logic [rrs_pkg::LEVEL_W-1:0]     hold_ticks,
	input  logic [rrs_pkg::LEVEL_W-1:0]     decay_step,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rrs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rrs_pkg::CFG_DAT_W-1:0]   cfg_data,
	// result strobe
	output logic                            done,
	output logic                            motor_on,
	output logic [rrs_pkg::LEVEL_W-1:0]     level,
	output logic                            wiped
);

	localparam int CNT_W = (REQUEST_SLOTS > 1) ? $clog2(REQUEST_SLOTS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(REQUEST_SLOTS - 1);

	// Sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SWEEP = 2'd1;
	localparam logic [1:0] S_OVR   = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0]                    state_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          found_q;
	logic [rrs_pkg::LEVEL_W-1:0]   best_q;
	logic                          tick_motor_q;
	rrs_pkg::slot_rec_t            ovr_q;
	logic                          upd_en_q;
	logic [rrs_pkg::ON_W-1:0]      max_on_q;
	logic [rrs_pkg::ON_W-1:0]      on_q;
	logic [rrs_pkg::OFF_W-1:0]     off_q;
	logic [rrs_pkg::MODE_W-1:0]    mode_q;
	logic                          done_q;
	logic                          res_motor_q;
	logic [rrs_pkg::LEVEL_W-1:0]   res_level_q;
	logic                          res_wiped_q;

	logic                          acc;
	logic                          clear_all;
	rrs_pkg::cell_ctl_t            cell_ctl;
	rrs_pkg::slot_rec_t            load_rec;
	rrs_pkg::slot_rec_t            cell_q   [REQUEST_SLOTS];
	rrs_pkg::slot_rec_t            cell_nbr [REQUEST_SLOTS];
	logic [REQUEST_SLOTS-1:0]      load_en;
	rrs_pkg::slot_rec_t            adv_in;
	rrs_pkg::slot_rec_t            adv_out;
	logic                          adv_carry;
	logic                          adv_live;

	// finish-stage values
	logic [rrs_pkg::LEVEL_W-1:0]   fin_level;
	logic [rrs_pkg::OFF_W-1:0]     off_inc;
	logic [rrs_pkg::ON_W-1:0]      on_inc;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = ~busy;
	assign acc       = start & ~busy;

	// Restart clears; so does any enabled tick that is not a running tick.
	assign clear_all = acc & ((func == rrs_pkg::FUNC_RESTART) |
		((func == rrs_pkg::FUNC_TICK) & upd_en_q & (mode_q != rrs_pkg::MODE_RUNNING)));

	assign cell_ctl.shift = (state_q == S_SWEEP);
	assign cell_ctl.clear = clear_all;

	assign load_rec = '{level: intensity, hold: hold_ticks, step: decay_step, accum: '0};

	// Ring of slot cells: cell 0 feeds the advance unit, whose result re-enters at the
	// tail, so after REQUEST_SLOTS shifts every slot sits back at its own cell.
	for (genvar gi = 0; gi < REQUEST_SLOTS; gi++) begin : g_cell
		if (gi == REQUEST_SLOTS - 1) begin : g_tail
			assign cell_nbr[gi] = adv_out;
		end else begin : g_link
			assign cell_nbr[gi] = cell_q[gi+1];
		end

		// slot indexes beyond the ring simply never match
		assign load_en[gi] = acc & (func == rrs_pkg::FUNC_LOAD_SLOT) &
			(32'(slot) == 32'(gi));

		rrs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (cell_ctl),
			.load_en  (load_en[gi]),
			.load_rec (load_rec),
			.nbr      (cell_nbr[gi]),
			.q        (cell_q[gi])
		);
	end

	// One advance unit, shared by the slot sweep and the override step.
	assign adv_in = (state_q == S_OVR) ? ovr_q : cell_q[0];

	rrs_adv u_adv (
		.rec_in  (adv_in),
		.rec_out (adv_out),
		.carry   (adv_carry),
		.live    (adv_live)
	);

	// Override slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovr_q <= '0;
		end else if (clear_all) begin
			ovr_q <= '0;
		end else if (acc && (func == rrs_pkg::FUNC_LOAD_OVR)) begin
			// keep the accumulator across a load
			ovr_q.level <= intensity;
			ovr_q.hold  <= hold_ticks;
			ovr_q.step  <= decay_step;
		end else if (state_q == S_OVR) begin
			ovr_q <= adv_out;
		end
	end

	// Level selection and rumble-time counters for the finish step.
	always_comb begin
		// a live override wins; otherwise the strongest slot (zero if none)
		fin_level = (ovr_q.level != '0) ? ovr_q.level : best_q;
		off_inc   = off_q + 1'b1;
		on_inc    = (on_q != rrs_pkg::ON_SAT) ? (on_q + 1'b1) : on_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			found_q      <= 1'b0;
			best_q       <= '0;
			tick_motor_q <= 1'b0;
			upd_en_q     <= 1'b1;
			max_on_q     <= rrs_pkg::MAX_ON_RESET;
			on_q         <= '0;
			off_q        <= '0;
			mode_q       <= rrs_pkg::MODE_INITIAL;
			done_q       <= 1'b0;
			res_motor_q  <= 1'b0;
			res_level_q  <= '0;
			res_wiped_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;

			// Configuration transactions are only offered while idle.
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					rrs_pkg::CFG_UPDATE_EN: upd_en_q <= cfg_data[0];
					rrs_pkg::CFG_MAX_ON:    max_on_q <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (func)
							rrs_pkg::FUNC_RESTART: begin
								mode_q   <= rrs_pkg::MODE_INITIAL;
								upd_en_q <= 1'b1;
								on_q     <= '0;
								off_q    <= '0;
							end
							rrs_pkg::FUNC_TICK: begin
								if (!upd_en_q) begin
									// updates off: motor off, no state change
									done_q      <= 1'b1;
									res_motor_q <= 1'b0;
									res_level_q <= '0;
									res_wiped_q <= (mode_q == rrs_pkg::MODE_WIPE);
								end else if (mode_q == rrs_pkg::MODE_WIPE) begin
									// wipe: drop everything, stay latched
									on_q        <= '0;
									off_q       <= '0;
									done_q      <= 1'b1;
									res_motor_q <= 1'b0;
									res_level_q <= '0;
									res_wiped_q <= 1'b1;
								end else if (mode_q == rrs_pkg::MODE_INITIAL) begin
									// first tick: clear, then an empty running tick
									mode_q      <= rrs_pkg::MODE_RUNNING;
									on_q        <= '0;
									off_q       <= rrs_pkg::OFF_W'(1);
									done_q      <= 1'b1;
									res_motor_q <= 1'b0;
									res_level_q <= '0;
									res_wiped_q <= 1'b0;
								end else begin
									// running: sweep the ring
									state_q      <= S_SWEEP;
									cnt_q        <= '0;
									found_q      <= 1'b0;
									best_q       <= '0;
									tick_motor_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				S_SWEEP: begin
					// strict compare keeps the earlier slot on ties
					if (adv_live && (!found_q || (best_q < adv_out.level))) begin
						found_q      <= 1'b1;
						best_q       <= adv_out.level;
						tick_motor_q <= adv_carry;
					end
					if (cnt_q == CNT_LAST) begin
						state_q <= S_OVR;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_OVR: begin
					// a live override drives the motor even if it decays to zero
					if (adv_live) begin
						tick_motor_q <= adv_carry;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_level == '0) begin
						if (off_inc > rrs_pkg::OFF_LIMIT) begin
							on_q  <= '0;
							off_q <= rrs_pkg::OFF_LIMIT;
						end else begin
							off_q <= off_inc;
						end
						res_wiped_q <= 1'b0;
					end else begin
						off_q <= '0;
						on_q  <= on_inc;
						if (on_inc > max_on_q) begin
							mode_q <= rrs_pkg::MODE_WIPE;
						end
						res_wiped_q <= (on_inc > max_on_q);
					end
					done_q      <= 1'b1;
					res_motor_q <= tick_motor_q;
					res_level_q <= fin_level;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done     = done_q;
	assign motor_on = res_motor_q;
	assign level    = res_level_q;
	assign wiped    = res_wiped_q;

	// Sweep ends after the last slot and hands over to the override step.
	`RRS_ASSERT_NEXT(a_sweep_to_ovr, (state_q == S_SWEEP) && (cnt_q == CNT_LAST),
		state_q == S_OVR, "ring sweep did not end at the last slot")
	// Every finish step delivers exactly one result.
	`RRS_ASSERT_NEXT(a_fin_done, state_q == S_FIN, done,
		"finish step produced no result")
	// A zero selected level can only come with a zero motor carry.
	`RRS_ASSERT_SAME(a_zero_level_off, done && (level == '0), !motor_on,
		"motor on with zero selected level")

endmodule

// ----- rtl/rrs_cell.sv -----
`timescale 1ns / 1ps
// One request slot of the scheduler ring: holds a slot record and hands it on.
// Depends on rrs_pkg.
module rrs_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  rrs_pkg::cell_ctl_t ctl,
	input  logic               load_en,
	input  rrs_pkg::slot_rec_t load_rec,
	input  rrs_pkg::slot_rec_t nbr,
	output rrs_pkg::slot_rec_t q
);

	rrs_pkg::slot_rec_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (ctl.clear) begin
			rec_q <= '0;
		end else if (load_en) begin
			// keep the accumulator across a load
			rec_q.level <= load_rec.level;
			rec_q.hold  <= load_rec.hold;
			rec_q.step  <= load_rec.step;
		end else if (ctl.shift) begin
			rec_q <= nbr;
		end
	end

	assign q = rec_q;

endmodule

// ----- rtl/rrs_adv.sv -----
`timescale 1ns / 1ps
// Slot advance unit: hold countdown, saturating decay and PWM accumulate.
// Depends on rrs_pkg.
module rrs_adv (
	input  rrs_pkg::slot_rec_t rec_in,
	output rrs_pkg::slot_rec_t rec_out,
	output logic               carry,
	output logic               live
);

	logic [rrs_pkg::LEVEL_W:0] sum;
	rrs_pkg::slot_rec_t        nxt;

	always_comb begin
		nxt  = rec_in;
		live = (rec_in.level != '0);
		if (rec_in.hold != '0) begin
			nxt.hold = rec_in.hold - 1'b1;
		end else if (rec_in.level > rec_in.step) begin
			nxt.level = rec_in.level - rec_in.step;
		end else begin
			nxt.level = '0;
		end
		sum = {1'b0, rec_in.accum} + {1'b0, nxt.level};
		nxt.accum = sum[rrs_pkg::LEVEL_W-1:0];
		// an empty slot stays untouched
		rec_out = live ? nxt : rec_in;
		carry   = live & sum[rrs_pkg::LEVEL_W];
	end

endmodule
